FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by the top level rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define CKRE_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
// condition must never be seen outside reset
`define CKRE_NEVER(lbl, ck, rs, cond, msg) \
  `CKRE_ASSERT(lbl, ck, rs, !(cond), msg)
`else
`define CKRE_ASSERT(lbl, ck, rs, prop, msg)
`define CKRE_NEVER(lbl, ck, rs, cond, msg)
`endif
`endif

FILE: sv/ckre_pkg.sv
// ---------------------------------------------------------------------------
// ckre_pkg
// shared types and constants of the color key run extractor
// ---------------------------------------------------------------------------
`default_nettype none
package ckre_pkg;

  localparam int PIX_W       = 24;
  localparam int COORD_W     = 13;
  localparam int ROW_W       = 12;
  localparam int CNT_OUT_W   = 11;
  localparam int MAX_WIDTH   = 4096;
  localparam int ROW_LIMIT   = 4096;
  localparam int BATCH_SIZE  = 2000;
  localparam int BATCH_CNT_W = $clog2(BATCH_SIZE + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [COORD_W-1:0] ROW_MAX   = '1;
  localparam logic [COORD_W-1:0] BOX_EMPTY = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COLOR    = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_BOUND_LEFT   = 3'd2,
    REG_BOUND_RIGHT  = 3'd3,
    REG_BOUND_TOP    = 3'd4,
    REG_BOUND_BOTTOM = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0]   key_color;
    logic [COORD_W-1:0] image_width;
    logic [COORD_W-1:0] bound_left;
    logic [COORD_W-1:0] bound_right;
    logic [COORD_W-1:0] bound_top;
    logic [COORD_W-1:0] bound_bottom;
  } cfg_regs_t;

  // what one pixel leaves for the back end
  typedef struct packed {
    logic               have_run;
    logic               flush;
    logic [ROW_W-1:0]   run_row;
    logic [ROW_W-1:0]   run_start;
    logic [COORD_W-1:0] run_end;
  } run_event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_FIRST,
    BK_FULL,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic                 kind;
    logic [ROW_W-1:0]     run_row;
    logic [ROW_W-1:0]     run_start;
    logic [COORD_W-1:0]   run_end;
    logic [COORD_W-1:0]   box_left;
    logic [COORD_W-1:0]   box_top;
    logic [COORD_W-1:0]   box_right;
    logic [COORD_W-1:0]   box_bottom;
    logic [CNT_OUT_W-1:0] box_count;
    logic                 last;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/ckre_ifs.sv
// ---------------------------------------------------------------------------
// ckre channel interfaces
// pixel input, result output and configuration write channels
// ---------------------------------------------------------------------------
`default_nettype none
interface ckre_pixel_if;
  import ckre_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             end_of_frame;
  modport source (output valid, pixel, end_of_frame, input ready);
  modport sink   (input valid, pixel, end_of_frame, output ready);
endinterface

interface ckre_result_if;
  import ckre_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ROW_W-1:0]     run_row;
  logic [ROW_W-1:0]     run_start;
  logic [COORD_W-1:0]   run_end;
  logic [COORD_W-1:0]   box_left;
  logic [COORD_W-1:0]   box_top;
  logic [COORD_W-1:0]   box_right;
  logic [COORD_W-1:0]   box_bottom;
  logic [CNT_OUT_W-1:0] box_count;
  logic                 last;
  modport source (output valid, kind, run_row, run_start, run_end, box_left, box_top,
                  box_right, box_bottom, box_count, last, input ready);
  modport sink   (input valid, kind, run_row, run_start, run_end, box_left, box_top,
                  box_right, box_bottom, box_count, last, output ready);
endinterface

interface ckre_cfg_if;
  import ckre_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/ckre_front.sv
// ---------------------------------------------------------------------------
// ckre_front
// raster position tracking and run detection, one pixel per clock while the queue is not full
// ---------------------------------------------------------------------------
`default_nettype none
module ckre_front (
  input  wire                      clk,
  input  wire                      rst,
  input  ckre_pkg::cfg_regs_t      cfg,
  ckre_pixel_if.sink               in_ch,
  input  ckre_pkg::queue_status_t  q_status,
  output logic                     push,
  output ckre_pkg::run_event_t     ev
);
  import ckre_pkg::*;

  logic [COORD_W-1:0] column, column_next;
  logic [COORD_W-1:0] row, row_next;
  logic               in_run, in_run_next;
  logic [ROW_W-1:0]   start_column, start_column_next;
  logic               flushed, flushed_next;

  logic               accept;
  logic [COORD_W-1:0] width_eff;
  logic [COORD_W-1:0] bottom_eff;
  logic [COORD_W:0]   col_inc;
  logic [COORD_W:0]   row_inc;
  logic               is_key, row_ok, row_end, eof, start_ok;
  logic               have_run, flush;
  logic [COORD_W-1:0] run_end;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign eof         = in_ch.end_of_frame;

  always_comb begin
    // width limited to 1..MAX_WIDTH, bottom bound to ROW_LIMIT
    if (cfg.image_width == '0) begin
      width_eff = COORD_W'(1);
    end else if (cfg.image_width > COORD_W'(MAX_WIDTH)) begin
      width_eff = COORD_W'(MAX_WIDTH);
    end else begin
      width_eff = cfg.image_width;
    end
    if (cfg.bound_bottom < COORD_W'(ROW_LIMIT)) begin
      bottom_eff = cfg.bound_bottom;
    end else begin
      bottom_eff = COORD_W'(ROW_LIMIT);
    end
  end

  assign col_inc  = {1'b0, column} + (COORD_W+1)'(1);
  assign row_inc  = {1'b0, row} + (COORD_W+1)'(1);
  assign is_key   = in_ch.pixel == cfg.key_color;
  assign row_ok   = (row >= cfg.bound_top) && (row < bottom_eff);
  assign row_end  = eof || (col_inc >= {1'b0, width_eff});
  assign start_ok = !is_key && row_ok && (column >= cfg.bound_left) &&
                    (column < cfg.bound_right) && (column < width_eff);

  always_comb begin
    have_run          = 1'b0;
    run_end           = '0;
    in_run_next       = in_run;
    start_column_next = start_column;
    if (in_run) begin
      if (is_key) begin
        have_run    = 1'b1;
        run_end     = column;
        in_run_next = 1'b0;
      end
    end else if (start_ok) begin
      in_run_next       = 1'b1;
      start_column_next = column[ROW_W-1:0];
    end
    // row end closes whatever is still open
    if (row_end && in_run_next) begin
      have_run    = 1'b1;
      run_end     = col_inc[COORD_W-1:0];
      in_run_next = 1'b0;
    end

    flush        = row_end && !flushed && (eof || row_inc >= {1'b0, bottom_eff});
    flushed_next = flushed || flush;

    if (eof) begin
      column_next  = '0;
      row_next     = '0;
      in_run_next  = 1'b0;
      flushed_next = 1'b0;
    end else if (row_end) begin
      column_next = '0;
      row_next    = (row < ROW_MAX) ? row_inc[COORD_W-1:0] : row;
    end else begin
      column_next = col_inc[COORD_W-1:0];
      row_next    = row;
    end
  end

  assign push         = accept && (have_run || flush);
  assign ev.have_run  = have_run;
  assign ev.flush     = flush;
  assign ev.run_row   = row[ROW_W-1:0];
  assign ev.run_start = start_column_next;
  assign ev.run_end   = run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      in_run       <= 1'b0;
      start_column <= '0;
      flushed      <= 1'b0;
    end else if (accept) begin
      column       <= column_next;
      row          <= row_next;
      in_run       <= in_run_next;
      start_column <= start_column_next;
      flushed      <= flushed_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ckre_queue.sv
// ---------------------------------------------------------------------------
// ckre_queue
// short event queue between the front end and the back end
// ---------------------------------------------------------------------------
`default_nettype none
module ckre_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  ckre_pkg::run_event_t     ev_in,
  input  wire                      pop,
  output ckre_pkg::run_event_t     head,
  output ckre_pkg::queue_status_t  status
);
  import ckre_pkg::*;

  run_event_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count, count_next;
  logic              do_push, do_pop;

  assign status.full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= ev_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ckre_back.sv
// ---------------------------------------------------------------------------
// ckre_back
// batch bounding box upkeep and result sequencing into the output register
// ---------------------------------------------------------------------------
`default_nettype none
module ckre_back (
  input  wire                      clk,
  input  wire                      rst,
  input  ckre_pkg::run_event_t     head,
  input  ckre_pkg::queue_status_t  q_status,
  output logic                     pop,
  ckre_result_if.source            out_ch
);
  import ckre_pkg::*;

  back_state_t            state, state_next;
  logic [BATCH_CNT_W-1:0] batch_runs, batch_runs_next;
  logic [COORD_W-1:0]     batch_left, batch_left_next;
  logic [COORD_W-1:0]     batch_top, batch_top_next;
  logic [COORD_W-1:0]     batch_right, batch_right_next;
  logic [COORD_W-1:0]     batch_bottom, batch_bottom_next;
  logic                   out_valid;
  result_t                out_data;

  logic                   out_free, emit;
  result_t                res, box_res;
  logic [COORD_W-1:0]     start_ext, row_ext, row_plus;
  logic [COORD_W-1:0]     upd_left, upd_top, upd_right, upd_bottom;
  logic [BATCH_CNT_W-1:0] upd_runs;
  logic                   full_hit;

  assign out_free  = !out_valid || out_ch.ready;
  assign start_ext = COORD_W'(head.run_start);
  assign row_ext   = COORD_W'(head.run_row);
  assign row_plus  = row_ext + COORD_W'(1);

  // batch after adding the head run
  assign upd_left   = (start_ext < batch_left) ? start_ext : batch_left;
  assign upd_top    = (row_ext < batch_top) ? row_ext : batch_top;
  assign upd_right  = (head.run_end > batch_right) ? head.run_end : batch_right;
  assign upd_bottom = (row_plus > batch_bottom) ? row_plus : batch_bottom;
  assign upd_runs   = batch_runs + BATCH_CNT_W'(1);
  assign full_hit   = upd_runs == BATCH_CNT_W'(BATCH_SIZE);

  always_comb begin
    box_res            = '0;
    box_res.kind       = 1'b1;
    box_res.box_left   = batch_left;
    box_res.box_top    = batch_top;
    box_res.box_right  = batch_right;
    box_res.box_bottom = batch_bottom;
    box_res.box_count  = CNT_OUT_W'(batch_runs);
  end

  always_comb begin
    state_next        = state;
    emit              = 1'b0;
    pop               = 1'b0;
    res               = box_res;
    batch_runs_next   = batch_runs;
    batch_left_next   = batch_left;
    batch_top_next    = batch_top;
    batch_right_next  = batch_right;
    batch_bottom_next = batch_bottom;
    if (!q_status.empty && out_free) begin
      emit = 1'b1;
      // a box record empties the batch unless overridden below
      batch_runs_next   = '0;
      batch_left_next   = BOX_EMPTY;
      batch_top_next    = BOX_EMPTY;
      batch_right_next  = '0;
      batch_bottom_next = '0;
      case (state)
        BK_FIRST: begin
          if (head.have_run) begin
            res               = '0;
            res.run_row       = head.run_row;
            res.run_start     = head.run_start;
            res.run_end       = head.run_end;
            batch_runs_next   = upd_runs;
            batch_left_next   = upd_left;
            batch_top_next    = upd_top;
            batch_right_next  = upd_right;
            batch_bottom_next = upd_bottom;
            if (full_hit) begin
              state_next = BK_FULL;
            end else if (head.flush) begin
              state_next = BK_FLUSH;
            end else begin
              res.last = 1'b1;
              pop      = 1'b1;
            end
          end else begin
            res.last = 1'b1;
            pop      = 1'b1;
          end
        end
        BK_FULL: begin
          if (head.flush) begin
            state_next = BK_FLUSH;
          end else begin
            res.last   = 1'b1;
            pop        = 1'b1;
            state_next = BK_FIRST;
          end
        end
        BK_FLUSH: begin
          res.last   = 1'b1;
          pop        = 1'b1;
          state_next = BK_FIRST;
        end
        default: begin
          emit              = 1'b0;
          state_next        = BK_FIRST;
          batch_runs_next   = batch_runs;
          batch_left_next   = batch_left;
          batch_top_next    = batch_top;
          batch_right_next  = batch_right;
          batch_bottom_next = batch_bottom;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_FIRST;
      batch_runs   <= '0;
      batch_left   <= BOX_EMPTY;
      batch_top    <= BOX_EMPTY;
      batch_right  <= '0;
      batch_bottom <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      batch_runs   <= batch_runs_next;
      batch_left   <= batch_left_next;
      batch_top    <= batch_top_next;
      batch_right  <= batch_right_next;
      batch_bottom <= batch_bottom_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_data <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_data.kind;
  assign out_ch.run_row    = out_data.run_row;
  assign out_ch.run_start  = out_data.run_start;
  assign out_ch.run_end    = out_data.run_end;
  assign out_ch.box_left   = out_data.box_left;
  assign out_ch.box_top    = out_data.box_top;
  assign out_ch.box_right  = out_data.box_right;
  assign out_ch.box_bottom = out_data.box_bottom;
  assign out_ch.box_count  = out_data.box_count;
  assign out_ch.last       = out_data.last;

endmodule
`default_nettype wire

FILE: sv/color_key_run_extractor_unit.sv
// ---------------------------------------------------------------------------
// color_key_run_extractor_unit
// color key run extraction with batch bounding boxes, top level
// ---------------------------------------------------------------------------
// Takes one 24-bit pixel per clock in raster order and emits a run record for
// every span of non-key pixels that starts inside the column and row bounds,
// plus a batch bounding box record each time a batch fills and once as the
// final flush after the last bounded row (or at end_of_frame). A pixel that
// causes no result produces nothing on the output; a pixel that causes
// results sends one to three of them, the last one flagged with last. The
// front end accepts a pixel every clock while the queue is not full and the
// back end moves one result per clock into a registered output while that
// register is free, so the first result of a pixel passes through the queue
// and then the output register before it is offered. A four-entry event
// queue absorbs pixels that cause two or three results, and input ready
// drops only while that queue is full. Ready stays high while results are
// taken as they come and extra records (full batch boxes and final flushes)
// do not arrive faster than the back end drains them; one-pixel frames that
// each close a run and flush slow input to the back end's pace. Configuration
// writes are always accepted and must only be issued while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module color_key_run_extractor_unit (
  input  wire           clk,
  input  wire           rst,
  ckre_pixel_if.sink    in_ch,
  ckre_result_if.source out_ch,
  ckre_cfg_if.sink      cfg
);
  import ckre_pkg::*;

  // configuration registers
  cfg_regs_t     cfg_regs;

  // front to queue to back
  logic          push;
  logic          pop;
  run_event_t    ev;
  run_event_t    head;
  queue_status_t q_status;

  // config channel never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.key_color    <= '0;
      cfg_regs.image_width  <= COORD_W'(640);
      cfg_regs.bound_left   <= '0;
      cfg_regs.bound_right  <= COORD_W'(640);
      cfg_regs.bound_top    <= '0;
      cfg_regs.bound_bottom <= COORD_W'(480);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_COLOR:    cfg_regs.key_color    <= cfg.data[PIX_W-1:0];
        REG_IMAGE_WIDTH:  cfg_regs.image_width  <= cfg.data[COORD_W-1:0];
        REG_BOUND_LEFT:   cfg_regs.bound_left   <= cfg.data[COORD_W-1:0];
        REG_BOUND_RIGHT:  cfg_regs.bound_right  <= cfg.data[COORD_W-1:0];
        REG_BOUND_TOP:    cfg_regs.bound_top    <= cfg.data[COORD_W-1:0];
        REG_BOUND_BOTTOM: cfg_regs.bound_bottom <= cfg.data[COORD_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // front end: position counters, key compare, run open and close
  ckre_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .ev       (ev)
  );

  // event queue, one entry per pixel that causes results
  ckre_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .ev_in  (ev),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  // back end: batch box and result sequencing
  ckre_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // queue cannot look full and empty at once
  `CKRE_NEVER(a_queue_level, clk, rst, q_status.full && q_status.empty, "queue level corrupt")
  // every run covers at least one pixel
  `CKRE_ASSERT(a_run_len, clk, rst, (out_ch.valid && !out_ch.kind) |-> (out_ch.run_end > COORD_W'(out_ch.run_start)), "empty run")
  // a non-empty box spans at least one column
  `CKRE_ASSERT(a_box_span, clk, rst, (out_ch.valid && out_ch.kind && out_ch.box_count != '0) |-> (out_ch.box_right > out_ch.box_left), "box without width")
  // an empty box carries the empty markers
  `CKRE_ASSERT(a_box_empty, clk, rst, (out_ch.valid && out_ch.kind && out_ch.box_count == '0) |-> (out_ch.box_left == BOX_EMPTY && out_ch.box_right == '0), "empty box not marked")

endmodule
`default_nettype wire
